/* rtl/core/nrmc_pkg.sv */
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, character codes and constant tables for the RMC sentence
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nrmc_pkg;

    // Default count of kept fraction digits
    localparam int FRAC_DIGITS_DEF = 6;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int FIELD_W    = 4;
    localparam int CNT_W      = 3;
    localparam int INT_W      = 17;
    localparam int SCALED_W   = 37;
    localparam int FRAC_W     = 20;
    localparam int LAT_W      = 34;
    localparam int LON_W      = 37;
    localparam int DIR_W      = 8;
    localparam int OUT_TDATA_W = 88;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;

    // Field indexes within the sentence
    localparam logic [FIELD_W-1:0] FLD_HDR     = 4'd0;
    localparam logic [FIELD_W-1:0] FLD_STATUS  = 4'd2;
    localparam logic [FIELD_W-1:0] FLD_LAT     = 4'd3;
    localparam logic [FIELD_W-1:0] FLD_LAT_DIR = 4'd4;
    localparam logic [FIELD_W-1:0] FLD_LON     = 4'd5;
    localparam logic [FIELD_W-1:0] FLD_LON_DIR = 4'd6;
    localparam logic [FIELD_W-1:0] FLD_MIN_OK  = 4'd5;
    localparam logic [FIELD_W-1:0] FLD_MAX     = 4'd15;

    localparam logic [CNT_W-1:0] HDR_LEN = 3'd6;
    localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

    // Integer part saturation limits
    localparam logic [INT_W-1:0] INT_SAT     = 17'd99999;
    localparam logic [INT_W-1:0] LAT_INT_MAX = 17'd9999;
    localparam logic [INT_W-1:0] LON_INT_MAX = 17'd99999;

    // One input character with its end mark
    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              end_of_sentence;
    } nrmc_item_t;

    // One parsed sentence
    typedef struct packed {
        logic              parse_status;
        logic [LAT_W-1:0]  latitude_minutes;
        logic [DIR_W-1:0]  latitude_hemisphere;
        logic [LON_W-1:0]  longitude_minutes;
        logic [DIR_W-1:0]  longitude_hemisphere;
    } nrmc_result_t;

    // Powers of ten up to 10^11
    function automatic logic [SCALED_W-1:0] pow10(input logic [3:0] n);
        logic [SCALED_W-1:0] p;
        unique case (n)
            4'd0:    p = 37'd1;
            4'd1:    p = 37'd10;
            4'd2:    p = 37'd100;
            4'd3:    p = 37'd1000;
            4'd4:    p = 37'd10000;
            4'd5:    p = 37'd100000;
            4'd6:    p = 37'd1000000;
            4'd7:    p = 37'd10000000;
            4'd8:    p = 37'd100000000;
            4'd9:    p = 37'd1000000000;
            4'd10:   p = 37'd10000000000;
            4'd11:   p = 37'd100000000000;
            default: p = 37'd0;
        endcase
        return p;
    endfunction

    // Expected header text "$GPRMC"
    function automatic logic [CHAR_W-1:0] hdr_char(input logic [CNT_W-1:0] k);
        logic [CHAR_W-1:0] ch;
        unique case (k)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nrmc_in_stage.sv */
// ----------------------------------------------------------------------------
// nrmc_in_stage
// Input register: captures one character word and holds it until the parse
// core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [nrmc_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_byte
    input  wire logic                        s_tlast,   // end_of_sentence
    input  wire logic                        take,
    output logic                             item_valid,
    output nrmc_pkg::nrmc_item_t             item
);
    import nrmc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    nrmc_item_t item_reg;

    // Free when empty or being drained this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= '{char_byte: s_tdata, end_of_sentence: s_tlast};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* rtl/core/nrmc_parse_core.sv */
// ----------------------------------------------------------------------------
// nrmc_parse_core
// Per-sentence parse state: header check, status flag, coordinate
// accumulators and held fields. One character is applied per step.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_parse_core #(
    parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_en,
    input  wire nrmc_pkg::nrmc_item_t item,
    output nrmc_pkg::nrmc_result_t    result
);
    import nrmc_pkg::*;

    localparam logic [SCALED_W-1:0] SCALE          = pow10(4'(FRAC_DIGITS));
    localparam logic [SCALED_W-1:0] INT_SAT_SCALED = pow10(4'(5 + FRAC_DIGITS)) - SCALE;
    localparam logic [SCALED_W-1:0] LAT_SAT_FULL   = pow10(4'(4 + FRAC_DIGITS)) - 37'd1;
    localparam logic [LAT_W-1:0]    LAT_SAT        = LAT_SAT_FULL[LAT_W-1:0];
    localparam logic [LON_W-1:0]    LON_SAT        = pow10(4'(5 + FRAC_DIGITS)) - 37'd1;
    localparam logic [CNT_W-1:0]    FRAC_LIMIT     = 3'(FRAC_DIGITS);
    localparam logic [3:0]          FRAC_TOP_EXP   = 4'(FRAC_DIGITS - 1);

    // State registers
    logic [FIELD_W-1:0]  field_reg,   field_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic                hdr_ok_reg,  hdr_ok_next;
    logic                stat_ok_reg, stat_ok_next;
    logic [INT_W-1:0]    int_reg,     int_next;
    logic [SCALED_W-1:0] isc_reg,     isc_next;
    logic [FRAC_W-1:0]   frac_reg,    frac_next;
    logic [CNT_W-1:0]    fcnt_reg,    fcnt_next;
    logic                point_reg,   point_next;
    logic [LAT_W-1:0]    lat_reg,     lat_next;
    logic [DIR_W-1:0]    lat_dir_reg, lat_dir_next;
    logic [LON_W-1:0]    lon_reg,     lon_next;
    logic [DIR_W-1:0]    lon_dir_reg, lon_dir_next;

    // After the character, before the end-of-sentence close
    logic [FIELD_W-1:0]  field_s1;
    logic [CNT_W-1:0]    cnt_s1;
    logic                hdr_ok_s1;
    logic                stat_ok_s1;
    logic [INT_W-1:0]    int_s1;
    logic [SCALED_W-1:0] isc_s1;
    logic [FRAC_W-1:0]   frac_s1;
    logic [CNT_W-1:0]    fcnt_s1;
    logic                point_s1;
    logic [LAT_W-1:0]    lat_s1;
    logic [DIR_W-1:0]    lat_dir_s1;
    logic [LON_W-1:0]    lon_s1;
    logic [DIR_W-1:0]    lon_dir_s1;

    logic [CHAR_W-1:0]   ch;
    logic                is_comma;
    logic                is_digit;
    logic [3:0]          digit;
    logic [INT_W+3:0]    int_mul;
    logic [SCALED_W+3:0] isc_mul;
    logic [3:0]          frac_exp;
    logic [SCALED_W-1:0] frac_prod;
    logic                hdr_ok_fin;
    logic                sent_ok;
    logic [LAT_W-1:0]    lat_fin;
    logic [LON_W-1:0]    lon_fin;

    // Coordinate value from the accumulators, saturated on the integer part
    function automatic logic [SCALED_W-1:0] coord(
        input logic [INT_W-1:0]    ival,
        input logic [SCALED_W-1:0] iscaled,
        input logic [FRAC_W-1:0]   fval,
        input logic [INT_W-1:0]    int_max,
        input logic [SCALED_W-1:0] sat
    );
        logic [SCALED_W-1:0] sum;
        sum = iscaled + {{(SCALED_W-FRAC_W){1'b0}}, fval};
        return (ival > int_max) ? sat : sum;
    endfunction

    // Character decode and digit arithmetic
    assign ch       = item.char_byte;
    assign is_comma = (ch == CH_COMMA);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);
    assign int_mul  = ({4'b0, int_reg} << 3) + ({4'b0, int_reg} << 1)
                    + {{INT_W{1'b0}}, digit};
    assign isc_mul  = ({4'b0, isc_reg} << 3) + ({4'b0, isc_reg} << 1)
                    + ({{SCALED_W{1'b0}}, digit} * {4'b0, SCALE});
    assign frac_exp  = FRAC_TOP_EXP - {1'b0, fcnt_reg};
    assign frac_prod = {{(SCALED_W-4){1'b0}}, digit} * pow10(frac_exp);

    // Apply the character: either close the field on a comma or take it
    always_comb
    begin
        field_s1   = field_reg;
        cnt_s1     = cnt_reg;
        hdr_ok_s1  = hdr_ok_reg;
        stat_ok_s1 = stat_ok_reg;
        int_s1     = int_reg;
        isc_s1     = isc_reg;
        frac_s1    = frac_reg;
        fcnt_s1    = fcnt_reg;
        point_s1   = point_reg;
        lat_s1     = lat_reg;
        lat_dir_s1 = lat_dir_reg;
        lon_s1     = lon_reg;
        lon_dir_s1 = lon_dir_reg;
        if (is_comma)
        begin
            if (field_reg == FLD_HDR && cnt_reg != HDR_LEN)
            begin
                hdr_ok_s1 = 1'b0;
            end
            if (field_reg == FLD_LAT)
            begin
                lat_s1 = LAT_W'(coord(int_reg, isc_reg, frac_reg, LAT_INT_MAX,
                                      {3'b0, LAT_SAT}));
            end
            if (field_reg == FLD_LON)
            begin
                lon_s1 = coord(int_reg, isc_reg, frac_reg, LON_INT_MAX, LON_SAT);
            end
            cnt_s1   = '0;
            int_s1   = '0;
            isc_s1   = '0;
            frac_s1  = '0;
            fcnt_s1  = '0;
            point_s1 = 1'b0;
            if (field_reg != FLD_MAX)
            begin
                field_s1 = field_reg + 4'd1;
            end
        end
        else
        begin
            // Fields other than the ones below only count characters
            if (field_reg == FLD_HDR)
            begin
                if (cnt_reg < HDR_LEN && ch != hdr_char(cnt_reg))
                begin
                    hdr_ok_s1 = 1'b0;
                end
            end
            else if (field_reg == FLD_STATUS)
            begin
                if (cnt_reg == '0)
                begin
                    stat_ok_s1 = (ch == CH_A);
                end
            end
            else if (field_reg == FLD_LAT || field_reg == FLD_LON)
            begin
                if (ch == CH_POINT)
                begin
                    point_s1 = 1'b1;
                end
                else if (is_digit)
                begin
                    if (!point_reg)
                    begin
                        // Integer part saturates
                        if (int_mul > {4'b0, INT_SAT})
                        begin
                            int_s1 = INT_SAT;
                            isc_s1 = INT_SAT_SCALED;
                        end
                        else
                        begin
                            int_s1 = int_mul[INT_W-1:0];
                            isc_s1 = isc_mul[SCALED_W-1:0];
                        end
                    end
                    else if (fcnt_reg < FRAC_LIMIT)
                    begin
                        frac_s1 = frac_reg + frac_prod[FRAC_W-1:0];
                        fcnt_s1 = fcnt_reg + 3'd1;
                    end
                end
            end
            else if (field_reg == FLD_LAT_DIR)
            begin
                if (cnt_reg == '0)
                begin
                    lat_dir_s1 = ch;
                end
            end
            else if (field_reg == FLD_LON_DIR)
            begin
                if (cnt_reg == '0)
                begin
                    lon_dir_s1 = ch;
                end
            end
            if (cnt_reg != CNT_MAX)
            begin
                cnt_s1 = cnt_reg + 3'd1;
            end
        end
    end

    // Final close at the end of the sentence
    assign hdr_ok_fin = hdr_ok_s1 && !(field_s1 == FLD_HDR && cnt_s1 != HDR_LEN);
    assign lat_fin    = (field_s1 == FLD_LAT)
                      ? LAT_W'(coord(int_s1, isc_s1, frac_s1, LAT_INT_MAX,
                                     {3'b0, LAT_SAT}))
                      : lat_s1;
    assign lon_fin    = (field_s1 == FLD_LON)
                      ? coord(int_s1, isc_s1, frac_s1, LON_INT_MAX, LON_SAT)
                      : lon_s1;
    assign sent_ok    = hdr_ok_fin && stat_ok_s1 && (field_s1 >= FLD_MIN_OK);

    always_comb
    begin
        result.parse_status         = !sent_ok;
        result.latitude_minutes     = sent_ok ? lat_fin    : '0;
        result.latitude_hemisphere  = sent_ok ? lat_dir_s1 : '0;
        result.longitude_minutes    = sent_ok ? lon_fin    : '0;
        result.longitude_hemisphere = sent_ok ? lon_dir_s1 : '0;
    end

    // Next state: cleared after each sentence
    always_comb
    begin
        if (item.end_of_sentence)
        begin
            field_next   = '0;
            cnt_next     = '0;
            hdr_ok_next  = 1'b1;
            stat_ok_next = 1'b0;
            int_next     = '0;
            isc_next     = '0;
            frac_next    = '0;
            fcnt_next    = '0;
            point_next   = 1'b0;
            lat_next     = '0;
            lat_dir_next = '0;
            lon_next     = '0;
            lon_dir_next = '0;
        end
        else
        begin
            field_next   = field_s1;
            cnt_next     = cnt_s1;
            hdr_ok_next  = hdr_ok_s1;
            stat_ok_next = stat_ok_s1;
            int_next     = int_s1;
            isc_next     = isc_s1;
            frac_next    = frac_s1;
            fcnt_next    = fcnt_s1;
            point_next   = point_s1;
            lat_next     = lat_s1;
            lat_dir_next = lat_dir_s1;
            lon_next     = lon_s1;
            lon_dir_next = lon_dir_s1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg   <= '0;
            cnt_reg     <= '0;
            hdr_ok_reg  <= 1'b1;
            stat_ok_reg <= 1'b0;
            int_reg     <= '0;
            isc_reg     <= '0;
            frac_reg    <= '0;
            fcnt_reg    <= '0;
            point_reg   <= 1'b0;
            lat_reg     <= '0;
            lat_dir_reg <= '0;
            lon_reg     <= '0;
            lon_dir_reg <= '0;
        end
        else if (step_en)
        begin
            field_reg   <= field_next;
            cnt_reg     <= cnt_next;
            hdr_ok_reg  <= hdr_ok_next;
            stat_ok_reg <= stat_ok_next;
            int_reg     <= int_next;
            isc_reg     <= isc_next;
            frac_reg    <= frac_next;
            fcnt_reg    <= fcnt_next;
            point_reg   <= point_next;
            lat_reg     <= lat_next;
            lat_dir_reg <= lat_dir_next;
            lon_reg     <= lon_next;
            lon_dir_reg <= lon_dir_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nrmc_out_stage.sv */
// ----------------------------------------------------------------------------
// nrmc_out_stage
// Result register: holds one parsed sentence until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_out_stage (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire nrmc_pkg::nrmc_result_t           result,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [33:0] latitude_minutes, [41:34] latitude_hemisphere,
    // [78:42] longitude_minutes, [86:79] longitude_hemisphere, [87] zero
    output logic [nrmc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tuser   // parse_status
);
    import nrmc_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    nrmc_result_t result_reg;

    assign valid_next = load ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    // Word packing
    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.parse_status;
    assign m_tdata  = {1'b0,
                       result_reg.longitude_hemisphere,
                       result_reg.longitude_minutes,
                       result_reg.latitude_hemisphere,
                       result_reg.latitude_minutes};

endmodule

`default_nettype wire

/* rtl/core/nmea_rmc_sentence_parser.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// Parses an RMC sentence streamed one character per word and emits one
// result word per sentence with latitude, longitude and hemispheres.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                                  | Marker
//  --------+-----------+------------------------------------------+-------------------
//  s_*     | in        | tdata[7:0] char_byte                     | tlast end_of_sentence
//  m_*     | out       | tdata: lat, lat hemi, lon, lon hemi      | tuser parse_status
//
//  One character word is accepted per cycle, back to back, except in the stall below.
//  After the last character of a sentence is accepted, it waits in the input
//  register and its result is then loaded into the result register.
//  The input stalls only when a last character meets a full result register
//  that the sink is not taking.
//  Reset clears the parse state; the first word after reset opens field 0.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_sentence_parser #(
    parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [nrmc_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] char_byte
    input  wire logic                             s_tlast,   // end_of_sentence
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [33:0] latitude_minutes, [41:34] latitude_hemisphere,
    // [78:42] longitude_minutes, [86:79] longitude_hemisphere, [87] zero
    output logic [nrmc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tuser    // parse_status
);
    import nrmc_pkg::*;

    logic         item_valid;
    nrmc_item_t   item;
    logic         advance;
    nrmc_result_t result;

    // A held character moves on unless it ends a sentence and the
    // result register is occupied and stalled
    assign advance = item_valid && (!item.end_of_sentence || !m_tvalid || m_tready);

    nrmc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nrmc_parse_core #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item),
        .result  (result)
    );

    nrmc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && item.end_of_sentence),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/nrmc_checker.sv */
// ----------------------------------------------------------------------------
// nrmc_checker
// Port-level checks for the RMC sentence parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             s_tlast,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [nrmc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tuser
);
    import nrmc_pkg::*;

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Rejected sentence carries all-zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("rejected sentence with nonzero fields");

    // Latitude never exceeds its saturation value
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[LAT_W-1:0] <= 34'd9999999999)
        else $error("latitude out of range");

    // A fresh result follows an accepted end character through the input and result registers
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without an accepted end character");

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (.*);

`default_nettype wire

/* sim/tb_nmea_rmc_sentence_parser.sv */
// ----------------------------------------------------------------------------
// tb_nmea_rmc_sentence_parser
// Streams RMC sentences into the parser one character word at a time. A
// behavioral decoder in the bench predicts the result word of every sentence,
// and each result word is checked field by field against the oldest
// prediction. Directed sentences come first, then random sentences and noise
// under changing source and sink idling, plus a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_nmea_rmc_sentence_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    localparam int FD          = FRAC_DIGITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 20;

    // "$GPRMC" as expected in field 0
    localparam logic [CHAR_W-1:0] RMC_TAG [6] = '{"$", "G", "P", "R", "M", "C"};

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t text_q_t[$];

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    int src_idle_pct    = 0;
    int sink_idle_pct   = 0;
    bit hold_req        = 1'b0;
    bit hold_sink       = 1'b0;
    int mismatch_count  = 0;
    int items_accepted  = 0;
    int cycle_count     = 0;

    // Expected result words, oldest first
    nrmc_result_t pending_fixes[$];

    // Decoder state of the bench
    logic [FIELD_W-1:0] fld_idx;
    logic [CNT_W-1:0]   fld_pos;
    bit                 hdr_good;
    bit                 fix_active;
    int unsigned        whole_acc;
    int unsigned        tail_acc;
    int                 frac_len;
    bit                 dot_seen;
    logic [63:0]        lat_value;
    logic [DIR_W-1:0]   lat_hemi;
    logic [63:0]        lon_value;
    logic [DIR_W-1:0]   lon_hemi;

    nmea_rmc_sentence_parser #(
        .FRAC_DIGITS (FD)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nmea_rmc_sentence_parser: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] ten_pow(input int n);
        logic [63:0] p;
        p = 64'd1;
        repeat (n) p = p * 64'd10;
        return p;
    endfunction

    // Fixed point value of the numeric field just closed
    function automatic logic [63:0] coord_fixed(input int unsigned int_lim);
        logic [63:0] scale;
        int          pad;
        scale = ten_pow(FD);
        if (whole_acc > int_lim)
            return (64'(int_lim) + 64'd1) * scale - 64'd1;
        pad = (frac_len < FD) ? FD - frac_len : 0;
        return 64'(whole_acc) * scale + 64'(tail_acc) * ten_pow(pad);
    endfunction

    function automatic void clear_rmc_state();
        fld_idx    = '0;
        fld_pos    = '0;
        hdr_good   = 1'b1;
        fix_active = 1'b0;
        whole_acc  = 0;
        tail_acc   = 0;
        frac_len   = 0;
        dot_seen   = 1'b0;
        lat_value  = '0;
        lat_hemi   = '0;
        lon_value  = '0;
        lon_hemi   = '0;
    endfunction

    function automatic void close_rmc_field();
        if (fld_idx == FLD_HDR && fld_pos != HDR_LEN)
            hdr_good = 1'b0;
        else if (fld_idx == FLD_LAT)
            lat_value = coord_fixed(LAT_INT_MAX);
        else if (fld_idx == FLD_LON)
            lon_value = coord_fixed(LON_INT_MAX);
        fld_pos   = '0;
        whole_acc = 0;
        tail_acc  = 0;
        frac_len  = 0;
        dot_seen  = 1'b0;
    endfunction

    function automatic void field_char(input logic [CHAR_W-1:0] c);
        int unsigned v;
        if (fld_idx == FLD_HDR)
        begin
            if (fld_pos < HDR_LEN && c != RMC_TAG[fld_pos])
                hdr_good = 1'b0;
        end
        else if (fld_idx == FLD_STATUS)
        begin
            if (fld_pos == 0)
                fix_active = (c == CH_A);
        end
        else if (fld_idx == FLD_LAT || fld_idx == FLD_LON)
        begin
            if (c == CH_POINT)
                dot_seen = 1'b1;
            else if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (!dot_seen)
                begin
                    v = whole_acc * 10 + (c - CH_ZERO);
                    whole_acc = (v > INT_SAT) ? INT_SAT : v;
                end
                else if (frac_len < FD)
                begin
                    tail_acc = tail_acc * 10 + (c - CH_ZERO);
                    frac_len++;
                end
            end
        end
        else if (fld_idx == FLD_LAT_DIR)
        begin
            if (fld_pos == 0)
                lat_hemi = c;
        end
        else if (fld_idx == FLD_LON_DIR)
        begin
            if (fld_pos == 0)
                lon_hemi = c;
        end
        if (fld_pos < CNT_MAX)
            fld_pos++;
    endfunction

    // One accepted character word; the last one of a sentence yields a fix
    function automatic void rmc_take_byte(input logic [CHAR_W-1:0] c, input bit last);
        nrmc_result_t r;
        bit           ok;
        if (c == CH_COMMA)
        begin
            close_rmc_field();
            if (fld_idx < FLD_MAX)
                fld_idx++;
        end
        else
            field_char(c);
        if (last)
        begin
            close_rmc_field();
            ok = hdr_good && fix_active && fld_idx >= FLD_MIN_OK;
            r.parse_status         = !ok;
            r.latitude_minutes     = ok ? lat_value[LAT_W-1:0] : '0;
            r.latitude_hemisphere  = ok ? lat_hemi : '0;
            r.longitude_minutes    = ok ? lon_value[LON_W-1:0] : '0;
            r.longitude_hemisphere = ok ? lon_hemi : '0;
            pending_fixes.push_back(r);
            clear_rmc_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Sink: check each accepted word, then pick next tready
    always @(posedge clk)
    begin
        nrmc_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_fixes.size() == 0)
                    report_mismatch("result word with none expected", m_tdata[63:0], '0);
                else
                begin
                    want = pending_fixes.pop_front();
                    if (m_tuser !== want.parse_status)
                        report_mismatch("parse_status", m_tuser, want.parse_status);
                    if (m_tdata[33:0] !== want.latitude_minutes)
                        report_mismatch("latitude_minutes", m_tdata[33:0],
                                        want.latitude_minutes);
                    if (m_tdata[41:34] !== want.latitude_hemisphere)
                        report_mismatch("latitude_hemisphere", m_tdata[41:34],
                                        want.latitude_hemisphere);
                    if (m_tdata[78:42] !== want.longitude_minutes)
                        report_mismatch("longitude_minutes", m_tdata[78:42],
                                        want.longitude_minutes);
                    if (m_tdata[86:79] !== want.longitude_hemisphere)
                        report_mismatch("longitude_hemisphere", m_tdata[86:79],
                                        want.longitude_hemisphere);
                    if (m_tdata[87] !== 1'b0)
                        report_mismatch("tdata pad bit", m_tdata[87], '0);
                end
            end
            m_tready <= hold_sink ? 1'b0 : ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Long sink hold-off, counted here
    initial
    begin
        forever
        begin
            wait (hold_req);
            @(negedge clk);
            hold_sink = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_sink = 1'b0;
            hold_req  = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    task automatic push_char(input logic [CHAR_W-1:0] c, input bit last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        items_accepted++;
        rmc_take_byte(c, last);
    endtask

    task automatic send_text(input text_q_t q);
        foreach (q[i])
            push_char(q[i], i == q.size() - 1);
    endtask

    // Drop valid and wait for a rising clock edge
    task automatic input_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_text(input string s, ref text_q_t q);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] junk_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    // Coordinate text: integer digits, optional fraction, rare stray bytes
    task automatic add_number(ref text_q_t q, input int max_int);
        int n_int;
        n_int = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_int) : max_int - 2;
        repeat (n_int) q.push_back(digit_char());
        if ($urandom_range(0, 9) < 8)
        begin
            q.push_back(CH_POINT);
            repeat ($urandom_range(0, 8)) q.push_back(digit_char());
        end
        if ($urandom_range(0, 9) == 0)
        begin
            q.push_back($urandom_range(0, 1) ? CH_POINT : junk_char());
            repeat ($urandom_range(0, 3)) q.push_back(digit_char());
        end
    endtask

    // Mostly well-formed RMC sentence with random content
    task automatic make_sentence(ref text_q_t q);
        int k;
        q.delete();
        case ($urandom_range(0, 19))
            0: repeat ($urandom_range(1, 8)) q.push_back(junk_char());
            1: load_text("$GPRM", q);
            2: load_text("$GPRMCC", q);
            3:
            begin
                load_text("$GPRMC", q);
                q[$urandom_range(0, 5)] = junk_char();
            end
            default: load_text("$GPRMC", q);
        endcase
        q.push_back(CH_COMMA);
        repeat ($urandom_range(0, 3)) q.push_back(digit_char());
        q.push_back(CH_COMMA);
        k = $urandom_range(0, 9);
        if (k < 8)
            q.push_back(CH_A);
        else if (k == 8)
            q.push_back(junk_char());
        if ($urandom_range(0, 4) == 0)
            q.push_back(junk_char());
        q.push_back(CH_COMMA);
        add_number(q, 6);
        q.push_back(CH_COMMA);
        k = $urandom_range(0, 9);
        if (k < 8)
            q.push_back($urandom_range(0, 1) ? "N" : "S");
        else if (k == 8)
            q.push_back(junk_char());
        q.push_back(CH_COMMA);
        add_number(q, 7);
        q.push_back(CH_COMMA);
        k = $urandom_range(0, 9);
        if (k < 8)
            q.push_back($urandom_range(0, 1) ? "E" : "W");
        else if (k == 8)
            q.push_back(junk_char());
        // trailing fields, now and then enough to pin the field count
        k = ($urandom_range(0, 14) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
        repeat (k)
        begin
            q.push_back(CH_COMMA);
            repeat ($urandom_range(0, 2)) q.push_back(junk_char());
        end
        if ($urandom_range(0, 7) == 0)
            q = q[0:$urandom_range(0, q.size() - 1)];
        if ($urandom_range(0, 9) == 0)
            q.push_back(CH_COMMA);
    endtask

    // Arbitrary bytes ending in one last word
    task automatic make_noise(ref text_q_t q);
        q.delete();
        repeat ($urandom_range(1, 12)) q.push_back(CHAR_W'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        text_q_t q;
        src_idle_pct  = 10;
        sink_idle_pct = 10;
        // header, status A and empty other fields, ended by a comma
        load_text("$GPRMC,,A,,,,", q);
        send_text(q);
        // top latitude, truncated fraction, stray bytes, 0xFF and 0x00 hemispheres
        q.delete();
        load_text("$GPRMC,1,A,9999.9999999x.5,", q);
        q.push_back(8'hFF);
        load_text(",99999999.9,", q);
        q.push_back(8'h00);
        send_text(q);
        // lone zero byte: header too short
        q.delete();
        q.push_back(8'h00);
        send_text(q);
        input_idle();
    endtask

    task automatic test_random(input int n_items, input int src_pct,
                               input int sink_pct);
        text_q_t q;
        int      start_items;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start_items   = items_accepted;
        while (items_accepted - start_items < n_items)
        begin
            if ($urandom_range(0, 99) < 85)
                make_sentence(q);
            else
                make_noise(q);
            send_text(q);
        end
        input_idle();
    endtask

    // Sink holds off while short sentences keep coming, then source waits
    task automatic test_backpressure();
        text_q_t q;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req = 1'b1;
        repeat (8)
        begin
            q.delete();
            load_text("$GPRMC,,A,", q);
            q.push_back(digit_char());
            load_text(",N,", q);
            q.push_back(digit_char());
            send_text(q);
        end
        input_idle();
        while (pending_fixes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clear_rmc_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(150, 23, 62);
        test_random(150, 62, 23);
        test_backpressure();
        test_random(150, 0, 0);

        while (pending_fixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatch_count == 0)
            $display("nmea_rmc_sentence_parser: match");
        else
            $display("nmea_rmc_sentence_parser: mismatch");
        $finish;
    end

endmodule
